// ===== hw/rtl/tcba_pkg.sv =====
// ----------------------------------------------------------------------------
// tcba_pkg
// Shared types and constants of the two-class batch arbiter.
// ----------------------------------------------------------------------------
package tcba_pkg;

   localparam int ID_W    = 8;
   localparam int DUR_W   = 8;
   localparam int ENTRY_W = ID_W + DUR_W;
   localparam int BS_W    = 4;

   localparam logic [BS_W-1:0] BATCH_SIZE_RESET = 4'd3;

   typedef enum logic [1:0] {
      RSP_ENQ   = 2'd0,
      RSP_DROP  = 2'd1,
      RSP_GRANT = 2'd2,
      RSP_IDLE  = 2'd3
   } rsp_status_type;

   typedef enum logic [1:0] {
      SERVED_NONE = 2'd0,
      SERVED_C0   = 2'd1,
      SERVED_C1   = 2'd2
   } served_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_GRANT = 2'd2
   } fsm_state_type;

   typedef enum logic {
      REQ_ARRIVE   = 1'b0,
      REQ_DISPATCH = 1'b1
   } req_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic exec_arrive;
      logic exec_idle;
      logic batch_start;
      logic grant_pop;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_arrive;
      logic both_empty;
      logic remain_last;
   } status_type;

endpackage

// ===== hw/rtl/tcba_ram.sv =====
// ----------------------------------------------------------------------------
// tcba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/tcba_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcba_ctrl
// Controller: sequences arrive, idle and batch grant operations.
// ----------------------------------------------------------------------------
module tcba_ctrl
   import tcba_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type dp_status,
   output cmd_type    dp_cmd,
   output logic       busy
);

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (!dp_status.is_arrive && !dp_status.both_empty) begin
               state_in = FSM_GRANT;
            end else begin
               state_in = FSM_IDLE;
            end
         end
         FSM_GRANT: begin
            if (dp_status.remain_last) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      busy   = 1'b1;
      unique case (state_ff)
         FSM_IDLE: begin
            busy           = 1'b0;
            dp_cmd.capture = start;
         end
         FSM_EXEC: begin
            dp_cmd.exec_arrive = dp_status.is_arrive;
            dp_cmd.exec_idle   = !dp_status.is_arrive && dp_status.both_empty;
            dp_cmd.batch_start = !dp_status.is_arrive && !dp_status.both_empty;
         end
         FSM_GRANT: begin
            dp_cmd.grant_pop = 1'b1;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== hw/rtl/tcba_dp.sv =====
// ----------------------------------------------------------------------------
// tcba_dp
// Datapath: class queues, pointers, batch counter, served class, result
// registers and the batch size register.
// ----------------------------------------------------------------------------
module tcba_dp
   import tcba_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int BATCH_MAX   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          dp_cmd,
   output status_type       dp_status,
   input  logic             req_type,
   input  logic             req_class,
   input  logic [ID_W-1:0]  req_id,
   input  logic [DUR_W-1:0] req_duration_tag,
   input  logic             csr_valid,
   input  logic [BS_W-1:0]  csr_batch_size,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_grant_class,
   output logic [ID_W-1:0]  rsp_grant_id,
   output logic [DUR_W-1:0] rsp_grant_duration,
   output logic             rsp_last
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int BW = $clog2(BATCH_MAX + 1);
   localparam int LW = (BW > BS_W) ? BW : BS_W;
   localparam int MW = (CW > LW) ? CW : LW;

   function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
      if (p == AW'(QUEUE_DEPTH - 1)) begin
         next_ptr = '0;
      end else begin
         next_ptr = p + AW'(1);
      end
   endfunction

   // captured request
   logic              req_type_ff;
   logic              req_class_ff;
   logic [ID_W-1:0]   req_id_ff;
   logic [DUR_W-1:0]  req_dur_ff;

   logic [BS_W-1:0]   batch_size_ff;
   logic [AW-1:0]     head0_ff, head0_in, head1_ff, head1_in;
   logic [CW-1:0]     count0_ff, count0_in, count1_ff, count1_in;
   served_type        served_ff, served_in;
   logic              pick_ff, pick_in;
   logic [BW-1:0]     remain_ff, remain_in;
   logic              rd_valid_ff, rd_last_ff, rd_class_ff;

   logic              strobe_ff, strobe_in;
   rsp_status_type    status_ff, status_in;
   logic              class_ff, class_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic              last_ff, last_in;

   logic [AW-1:0]     sel_head;
   logic [CW-1:0]     sel_count;
   logic [AW:0]       tail_sum;
   logic [AW-1:0]     tail;
   logic              sel_full;
   logic              push0, push1;
   logic              pick_sel;
   logic [CW-1:0]     pick_count;
   logic [LW-1:0]     bs_ext, lim;
   logic [MW-1:0]     cnt_ext, lim_ext, n_items;
   logic [ENTRY_W-1:0] rd0_data, rd1_data, rd_entry, wr_entry;

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         req_type_ff  <= req_type;
         req_class_ff <= req_class;
         req_id_ff    <= req_id;
         req_dur_ff   <= req_duration_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_size_ff <= BATCH_SIZE_RESET;
      end else if (csr_valid) begin
         batch_size_ff <= csr_batch_size;
      end
   end

   // arrive path
   always_comb begin
      sel_head  = req_class_ff ? head1_ff : head0_ff;
      sel_count = req_class_ff ? count1_ff : count0_ff;
      sel_full  = (sel_count == CW'(QUEUE_DEPTH));
      tail_sum  = (AW+1)'(sel_head) + (AW+1)'(sel_count);
      if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (AW+1)'(QUEUE_DEPTH);
      end
      tail     = tail_sum[AW-1:0];
      push0    = dp_cmd.exec_arrive && !sel_full && !req_class_ff;
      push1    = dp_cmd.exec_arrive && !sel_full && req_class_ff;
      wr_entry = {req_id_ff, req_dur_ff};
   end

   // class pick and batch length
   always_comb begin
      if (count0_ff == '0) begin
         pick_sel = 1'b1;
      end else if (count1_ff == '0) begin
         pick_sel = 1'b0;
      end else begin
         pick_sel = (served_ff == SERVED_C0);
      end
      pick_count = pick_sel ? count1_ff : count0_ff;
      bs_ext     = LW'(batch_size_ff);
      if (bs_ext == '0) begin
         lim = LW'(1);
      end else if (bs_ext > LW'(BATCH_MAX)) begin
         lim = LW'(BATCH_MAX);
      end else begin
         lim = bs_ext;
      end
      cnt_ext = MW'(pick_count);
      lim_ext = MW'(lim);
      n_items = (cnt_ext < lim_ext) ? cnt_ext : lim_ext;
   end

   // pointer, count and batch state
   always_comb begin
      head0_in  = head0_ff;
      head1_in  = head1_ff;
      count0_in = count0_ff;
      count1_in = count1_ff;
      served_in = served_ff;
      pick_in   = pick_ff;
      remain_in = remain_ff;
      if (push0) begin
         count0_in = count0_ff + CW'(1);
      end
      if (push1) begin
         count1_in = count1_ff + CW'(1);
      end
      if (dp_cmd.batch_start) begin
         pick_in   = pick_sel;
         remain_in = BW'(n_items);
         served_in = pick_sel ? SERVED_C1 : SERVED_C0;
      end
      if (dp_cmd.grant_pop) begin
         remain_in = remain_ff - BW'(1);
         if (pick_ff) begin
            head1_in  = next_ptr(head1_ff);
            count1_in = count1_ff - CW'(1);
         end else begin
            head0_in  = next_ptr(head0_ff);
            count0_in = count0_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head0_ff    <= '0;
         head1_ff    <= '0;
         count0_ff   <= '0;
         count1_ff   <= '0;
         served_ff   <= SERVED_NONE;
         remain_ff   <= '0;
         pick_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         head0_ff    <= head0_in;
         head1_ff    <= head1_in;
         count0_ff   <= count0_in;
         count1_ff   <= count1_in;
         served_ff   <= served_in;
         remain_ff   <= remain_in;
         pick_ff     <= pick_in;
         rd_valid_ff <= dp_cmd.grant_pop;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_last_ff  <= (remain_ff == BW'(1));
      rd_class_ff <= pick_ff;
   end

   tcba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram0 (
      .clock   (clock),
      .wr_en   (push0),
      .wr_addr (tail),
      .wr_data (wr_entry),
      .rd_addr (head0_ff),
      .rd_data (rd0_data)
   );

   tcba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram1 (
      .clock   (clock),
      .wr_en   (push1),
      .wr_addr (tail),
      .wr_data (wr_entry),
      .rd_addr (head1_ff),
      .rd_data (rd1_data)
   );

   assign rd_entry = rd_class_ff ? rd1_data : rd0_data;

   // result register
   always_comb begin
      strobe_in = 1'b0;
      status_in = status_ff;
      class_in  = class_ff;
      id_in     = id_ff;
      dur_in    = dur_ff;
      last_in   = last_ff;
      if (dp_cmd.exec_arrive) begin
         strobe_in = 1'b1;
         status_in = sel_full ? RSP_DROP : RSP_ENQ;
         class_in  = req_class_ff;
         id_in     = req_id_ff;
         dur_in    = req_dur_ff;
         last_in   = 1'b1;
      end else if (dp_cmd.exec_idle) begin
         strobe_in = 1'b1;
         status_in = RSP_IDLE;
         class_in  = 1'b0;
         id_in     = '0;
         dur_in    = '0;
         last_in   = 1'b1;
      end else if (rd_valid_ff) begin
         strobe_in = 1'b1;
         status_in = RSP_GRANT;
         class_in  = rd_class_ff;
         id_in     = rd_entry[ENTRY_W-1:DUR_W];
         dur_in    = rd_entry[DUR_W-1:0];
         last_in   = rd_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      class_ff  <= class_in;
      id_ff     <= id_in;
      dur_ff    <= dur_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_grant_class    = class_ff;
   assign rsp_grant_id       = id_ff;
   assign rsp_grant_duration = dur_ff;
   assign rsp_last           = last_ff;

   assign dp_status.is_arrive   = (req_type_ff == REQ_ARRIVE);
   assign dp_status.both_empty  = (count0_ff == '0) && (count1_ff == '0);
   assign dp_status.remain_last = (remain_ff == BW'(1));

endmodule

// ===== hw/rtl/two_class_batch_arbiter.sv =====
// ----------------------------------------------------------------------------
// two_class_batch_arbiter
// Two FIFO request queues served in batches, alternating when both hold work.
//
// channel  ports                        handshake
// req      req_type/class/id/dur_tag    start & !busy
// rsp      rsp_status/grant_*/last      rsp_strobe, one cycle, no stall
// csr      csr_batch_size               csr_valid & csr_ready (always ready)
//
// Arrive and idle dispatch: the request is captured on accept and executed
// in the EXEC state, its result registered; then the block accepts again.
// Dispatch with n grants: busy in EXEC, then in GRANT for each grant.
// Grants leave one per cycle through the queue RAM's registered read and
// the result register. Synchronous reset clears pointers, counts and
// control; queue RAMs are not cleared. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module two_class_batch_arbiter
   import tcba_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int BATCH_MAX   = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_type,
   input  logic             req_class,
   input  logic [ID_W-1:0]  req_id,
   input  logic [DUR_W-1:0] req_duration_tag,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic             rsp_grant_class,
   output logic [ID_W-1:0]  rsp_grant_id,
   output logic [DUR_W-1:0] rsp_grant_duration,
   output logic             rsp_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [BS_W-1:0]  csr_batch_size
);

   cmd_type    dp_cmd;
   status_type dp_status;

   assign csr_ready = 1'b1;

   tcba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd),
      .busy      (busy)
   );

   tcba_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .BATCH_MAX   (BATCH_MAX)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .req_type           (req_type),
      .req_class          (req_class),
      .req_id             (req_id),
      .req_duration_tag   (req_duration_tag),
      .csr_valid          (csr_valid && csr_ready),
      .csr_batch_size     (csr_batch_size),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_grant_class    (rsp_grant_class),
      .rsp_grant_id       (rsp_grant_id),
      .rsp_grant_duration (rsp_grant_duration),
      .rsp_last           (rsp_last)
   );

   a_arrive_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_type == REQ_ARRIVE) |-> ##2 (rsp_strobe && rsp_last))
      else $error("arrive item without its result");

   a_batch_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == RSP_GRANT && !rsp_last) |=>
      (rsp_strobe && rsp_status == RSP_GRANT && $stable(rsp_grant_class)))
      else $error("grant batch broken or class changed");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != RSP_GRANT) |-> rsp_last)
      else $error("non-grant result not marked last");

   a_busy_dispatch: assert property (@(posedge clock) disable iff (reset)
      (dp_cmd.batch_start) |=> busy)
      else $error("batch started without busy");

endmodule
